// ===== src/bsr_pkg.sv =====
// Shared types and constants of the blocked section registry.
`default_nettype none

package bsr_pkg;

  // Widths fixed by the item formats.
  localparam int KIND_W   = 3;
  localparam int KEY_W    = 64;
  localparam int STREAM_W = 32;
  localparam int OCC_OUT_W = 5;
  localparam int MAXB_W   = 5;

  // Default table depth.
  localparam int CAPACITY_DEF = 16;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_MAX_BLOCKED = 1'b0;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_ADD        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_STREAM = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REM_STREAM = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOTIFY     = 3'd5;

  // Search token that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
    logic [STREAM_W-1:0] stream;
    logic                hit;
    logic [KEY_W-1:0]    hit_key;
    logic                free_hit;
  } bsr_tok_t;

endpackage

`default_nettype wire

// ===== src/bsr_if.sv =====
// Handshake channel interfaces for the request and result transactions.
`default_nettype none

interface bsr_in_if;
  import bsr_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_W-1:0]    entry_key;
  logic [STREAM_W-1:0] stream_number;

  modport source (output valid, kind, entry_key, stream_number, input ready);
  modport sink (input valid, kind, entry_key, stream_number, output ready);
endinterface

interface bsr_out_if;
  import bsr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic                 fire;
  logic [KEY_W-1:0]     result_key;
  logic [OCC_OUT_W-1:0] occupancy;
  logic                 last;

  modport source (output valid, ok, fire, result_key, occupancy, last, input ready);
  modport sink (input valid, ok, fire, result_key, occupancy, last, output ready);
endinterface

`default_nettype wire

// ===== src/bsr_cell.sv =====
// One table slot: holds a key and its valid bit and forwards the search token.
`default_nettype none

module bsr_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire bsr_pkg::bsr_tok_t    tok_i,
  output bsr_pkg::bsr_tok_t         tok_o,
  input  wire                       wr_en,
  input  wire [bsr_pkg::KEY_W-1:0]  wr_key,
  input  wire                       clr_en,
  input  wire [bsr_pkg::KEY_W-1:0]  clr_key,
  output logic                      valid_o,
  output logic [bsr_pkg::KEY_W-1:0] key_o
);
  import bsr_pkg::*;

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic             claim_r;
  bsr_tok_t         tok_r;
  bsr_tok_t         tok_nxt;

  logic is_stream;
  logic match_key;
  logic match_stream;

  // Fold this slot into the token: exact key match, or smallest key of a stream.
  always_comb begin
    is_stream    = (tok_i.kind == KIND_ACK_STREAM) || (tok_i.kind == KIND_REM_STREAM);
    match_key    = valid_r && (key_r == tok_i.key);
    match_stream = valid_r && (key_r[KEY_W-1:KEY_W-STREAM_W] == tok_i.stream);
    tok_nxt      = tok_i;
    if (is_stream) begin
      if (match_stream && (!tok_i.hit || (key_r < tok_i.hit_key))) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_key = key_r;
      end
    end else if (match_key) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_key = key_r;
    end
    tok_nxt.free_hit = tok_i.free_hit || !valid_r;
  end

  // Token stage and the free-slot claim of the current search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      claim_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (tok_i.valid) begin
        claim_r <= !tok_i.free_hit && !valid_r;
      end
    end
  end

  // Slot contents: written when this cell holds the claim, cleared by key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en && claim_r) begin
      valid_r <= 1'b1;
    end else if (clr_en && valid_r && (key_r == clr_key)) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && claim_r) begin
      key_r <= wr_key;
    end
  end

  assign tok_o   = tok_r;
  assign valid_o = valid_r;
  assign key_o   = key_r;

endmodule

`default_nettype wire

// ===== src/blocked_section_registry_unit.sv =====
// Blocked section registry: request decode, row of slot cells and result register.
//
// Usage: a request transaction on in_ch carries kind, entry_key and
// stream_number. Each request is searched by a token that walks the row of
// CAPACITY slot cells, one cell per clock, so the key match, duplicate check,
// lowest free slot and smallest key of a stream are all known once the token
// leaves the last cell. One request is in flight at a time: in_ch.ready is
// high only while the block is idle. For a request that gives a single result
// transaction, the search outcome is captured from the last cell, then loaded
// into the result register that drives out_ch.valid, and the next request can
// be taken on the cycle after that result is registered.
// Notify all walks the slots one per cycle after the search, unless the
// output stalls, and emits one result per pending key, in slot order; an
// empty table gives one result. Results sit in an output register; while
// out_ch.ready is low the register holds and the block waits. max_blocked is
// written through the cfg_ APB port. A synchronous reset (rst_n low) empties
// the table, drops any request in flight and sets max_blocked to zero.
`default_nettype none

module blocked_section_registry_unit #(
  parameter int CAPACITY = bsr_pkg::CAPACITY_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  bsr_in_if.sink                        in_ch,
  bsr_out_if.source                     out_ch,
  input  wire                           cfg_psel,
  input  wire                           cfg_penable,
  input  wire                           cfg_pwrite,
  input  wire [bsr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire [bsr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bsr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import bsr_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > MAXB_W) ? OCC_W : MAXB_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_NOTE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [MAXB_W-1:0] max_r;
  bsr_tok_t         res_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 ok_r, ok_nxt;
  logic                 fire_r, fire_nxt;
  logic [KEY_W-1:0]     rkey_r, rkey_nxt;
  logic [OCC_OUT_W-1:0] rocc_r, rocc_nxt;
  logic                 last_r, last_nxt;
  logic                 load_out;

  bsr_tok_t         tok_chain [CAPACITY+1];
  logic             cell_valid [CAPACITY];
  logic [KEY_W-1:0] cell_key [CAPACITY];

  logic             wr_en;
  logic             clr_en;
  logic [KEY_W-1:0] clr_key;

  logic             in_ready;
  logic             out_free;
  logic [CMP_W-1:0] limit;
  logic             occ_full;
  logic             sel_valid;
  logic [KEY_W-1:0] sel_key;

  // Configuration register, written in the APB access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[CFG_ADDR_W-1] == REG_MAX_BLOCKED)) begin
      max_r <= cfg_pwdata[MAXB_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_MAX_BLOCKED) ?
                      CFG_DATA_W'(max_r) : '0;

  // Limit in force saturates at the table depth.
  assign limit    = (CMP_W'(max_r) < CMP_W'(CAPACITY)) ? CMP_W'(max_r) : CMP_W'(CAPACITY);
  assign occ_full = CMP_W'(occ_r) >= limit;

  // Launch a fresh token into the first cell on each accepted request.
  assign in_ready = (state_r == ST_IDLE);
  assign in_ch.ready = in_ready;

  always_comb begin
    tok_chain[0]          = '0;
    tok_chain[0].valid    = in_ch.valid && in_ready;
    tok_chain[0].kind     = in_ch.kind;
    tok_chain[0].key      = in_ch.entry_key;
    tok_chain[0].stream   = in_ch.stream_number;
  end

  // Row of slot cells.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    bsr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok_chain[gi]),
      .tok_o   (tok_chain[gi+1]),
      .wr_en   (wr_en),
      .wr_key  (res_r.key),
      .clr_en  (clr_en),
      .clr_key (clr_key),
      .valid_o (cell_valid[gi]),
      .key_o   (cell_key[gi])
    );
  end

  // Slot visited by the notify walk.
  assign sel_valid = cell_valid[ptr_r];
  assign sel_key   = cell_key[ptr_r];

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer: wait for the token, commit the result, then walk on notify.
  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    ptr_nxt   = ptr_r;
    wr_en     = 1'b0;
    clr_en    = 1'b0;
    clr_key   = res_r.hit_key;
    load_out  = 1'b0;
    ok_nxt    = 1'b0;
    fire_nxt  = 1'b0;
    rkey_nxt  = '0;
    last_nxt  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (tok_chain[CAPACITY].valid) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if ((res_r.kind == KIND_NOTIFY) && (occ_r != '0)) begin
          ptr_nxt   = '0;
          state_nxt = ST_NOTE;
        end else if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          case (res_r.kind)
            KIND_ADD: begin
              if (!occ_full) begin
                ok_nxt = 1'b1;
                if (!res_r.hit) begin
                  wr_en   = 1'b1;
                  occ_nxt = occ_r + 1'b1;
                end
              end
            end
            KIND_ACK, KIND_REMOVE, KIND_ACK_STREAM, KIND_REM_STREAM: begin
              if (res_r.hit) begin
                clr_en  = 1'b1;
                occ_nxt = occ_r - 1'b1;
                ok_nxt  = 1'b1;
                if ((res_r.kind == KIND_ACK) || (res_r.kind == KIND_ACK_STREAM)) begin
                  fire_nxt = 1'b1;
                  rkey_nxt = res_r.hit_key;
                end
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_NOTE: begin
        if (!sel_valid) begin
          ptr_nxt = ptr_r + 1'b1;
        end else if (out_free) begin
          load_out = 1'b1;
          clr_en   = 1'b1;
          clr_key  = sel_key;
          occ_nxt  = occ_r - 1'b1;
          ok_nxt   = 1'b1;
          fire_nxt = 1'b1;
          rkey_nxt = sel_key;
          last_nxt = (occ_r == OCC_W'(1));
          ptr_nxt  = ptr_r + 1'b1;
          if (occ_r == OCC_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rocc_nxt      = OCC_OUT_W'(occ_nxt);
  assign out_valid_nxt = load_out || (out_valid_r && !out_ch.ready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Search outcome captured at the end of the row.
  always_ff @(posedge clk) begin
    if (tok_chain[CAPACITY].valid) begin
      res_r <= tok_chain[CAPACITY];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      ok_r   <= ok_nxt;
      fire_r <= fire_nxt;
      rkey_r <= rkey_nxt;
      rocc_r <= rocc_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = ok_r;
  assign out_ch.fire       = fire_r;
  assign out_ch.result_key = rkey_r;
  assign out_ch.occupancy  = rocc_r;
  assign out_ch.last       = last_r;

endmodule

`default_nettype wire

// ===== src/bsr_checker.sv =====
// Port-level checks of the registry's result channel, bound to the top level.
`default_nettype none

module bsr_checker #(
  parameter int CAPACITY = bsr_pkg::CAPACITY_DEF
) (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire                              out_ok,
  input wire                              out_fire,
  input wire [bsr_pkg::KEY_W-1:0]         out_result_key,
  input wire [bsr_pkg::OCC_OUT_W-1:0]     out_occupancy
);
  import bsr_pkg::*;

  // A stalled result transaction stays valid and keeps its key and occupancy.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_key) &&
                                $stable(out_occupancy))
    else $error("result changed while stalled");

  // A retry report always comes from a successful deletion.
  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fire |-> out_ok)
    else $error("fire without ok");

  // Only reported keys carry a nonzero key.
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fire |-> (out_result_key == '0))
    else $error("key on a non-fire result");

  // Occupancy never exceeds the table depth.
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_occupancy) <= 32'(CAPACITY)))
    else $error("occupancy above capacity");

  // No result is shown right after reset.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind blocked_section_registry_unit bsr_checker #(.CAPACITY(CAPACITY)) u_bsr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_ok         (out_ch.ok),
  .out_fire       (out_ch.fire),
  .out_result_key (out_ch.result_key),
  .out_occupancy  (out_ch.occupancy)
);

`default_nettype wire
